FILE: sv/rpic_pkg.sv
// ----------------------------------------------------------------------------
// rpic_pkg
// Shared types and constants of the RC pulse input conditioner: register
// indexes, reset values, switch codes and the divider request.
// ----------------------------------------------------------------------------
package rpic_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_WIDTH_LOW    = 3'd0;
    localparam logic [2:0] CFG_WIDTH_HIGH   = 3'd1;
    localparam logic [2:0] CFG_WIDTH_MID    = 3'd2;
    localparam logic [2:0] CFG_DEAD_MARGIN  = 3'd3;
    localparam logic [2:0] CFG_DEAD_WIDTH   = 3'd4;
    localparam logic [2:0] CFG_MODE_GUARD   = 3'd5;
    localparam logic [2:0] CFG_SWITCH_DELAY = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int CNT_W      = 18;   // width of a clamped pulse count
    localparam int MAG_W      = 20;   // divider operand width

    // Register reset values
    localparam logic [17:0] RST_WIDTH_LOW    = 18'd111000;
    localparam logic [17:0] RST_WIDTH_HIGH   = 18'd190000;
    localparam logic [17:0] RST_WIDTH_MID    = 18'd150000;
    localparam logic [15:0] RST_DEAD_MARGIN  = 16'd6000;
    localparam logic [17:0] RST_DEAD_WIDTH   = 18'd0;
    localparam logic [15:0] RST_MODE_GUARD   = 16'd20000;
    localparam logic [7:0]  RST_SWITCH_DELAY = 8'd10;

    // Flight mode codes
    localparam logic [1:0] MODE_MANUAL   = 2'd0;
    localparam logic [1:0] MODE_ALTITUDE = 2'd1;
    localparam logic [1:0] MODE_NAVIGATE = 2'd2;
    localparam logic [1:0] MODE_ERROR    = 2'd3;

    // Inductive switch codes
    localparam logic [1:0] SW_OFF   = 2'd0;
    localparam logic [1:0] SW_ON    = 2'd1;
    localparam logic [1:0] SW_ERROR = 2'd2;

    typedef struct packed {
        logic [17:0] width_low;
        logic [17:0] width_high;
        logic [17:0] width_mid;
        logic [15:0] dead_margin;
        logic [17:0] dead_width;
        logic [15:0] mode_guard;
        logic [7:0]  switch_delay;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] num;   // dividend, below den
        logic [MAG_W-1:0] den;
    } t_div_req;

endpackage

FILE: sv/rpic_divider.sv
// ----------------------------------------------------------------------------
// rpic_divider
// Restoring fractional divider: quotient = floor(num * 2^FRACTION_BITS / den)
// for num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpic_divider #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rpic_pkg::t_div_req      i_req,
    output logic                    o_done,
    output logic [FRACTION_BITS-1:0] o_quo
);
    import rpic_pkg::*;

    localparam int STEP_W = $clog2(FRACTION_BITS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRACTION_BITS - 1);

    logic                     r_busy;
    logic [STEP_W-1:0]        r_step;
    logic [MAG_W-1:0]         r_rem;
    logic [MAG_W-1:0]         r_den;
    logic [FRACTION_BITS-1:0] r_quo;
    logic                     r_done;

    logic [MAG_W:0] trial;
    logic [MAG_W:0] diff;
    logic           take;

    always_comb begin
        trial = {r_rem, 1'b0};
        diff  = trial - {1'b0, r_den};
        take  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            // Pulse done for one cycle after the last quotient bit
            r_done <= r_busy && (r_step == LAST_STEP);
            if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end
        end
    end

    // Datapath: load on start, shift one quotient bit in per step
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= take ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            r_quo <= {r_quo[FRACTION_BITS-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: sv/rpic_mode_filter.sv
// ----------------------------------------------------------------------------
// rpic_mode_filter
// Classify the mode and inductive switch widths against the guard band and
// debounce both with mismatch counters.
// ----------------------------------------------------------------------------
module rpic_mode_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rpic_pkg::t_cfg              i_cfg,
    input  logic [rpic_pkg::CNT_W-1:0]  i_mode_w,
    input  logic [rpic_pkg::CNT_W-1:0]  i_switch_w,
    input  logic                        i_update,
    output logic [1:0]                  o_mode,
    output logic [1:0]                  o_switch
);
    import rpic_pkg::*;

    logic [1:0] r_held_mode;
    logic [7:0] r_mode_cnt;
    logic [1:0] r_held_sw;
    logic [7:0] r_sw_cnt;
    logic [1:0] n_held_mode;
    logic [7:0] n_mode_cnt;
    logic [1:0] n_held_sw;
    logic [7:0] n_sw_cnt;

    logic [CNT_W:0]          low_guard;
    logic [CNT_W:0]          mid_guard;
    logic signed [CNT_W+1:0] high_guard;
    logic [1:0]              fresh_mode;
    logic [1:0]              fresh_sw;
    logic [7:0]              mode_inc;
    logic [7:0]              sw_inc;

    always_comb begin
        low_guard  = {1'b0, i_cfg.width_low} + {3'b0, i_cfg.mode_guard};
        mid_guard  = {1'b0, i_cfg.width_mid} + {3'b0, i_cfg.mode_guard};
        high_guard = $signed({2'b0, i_cfg.width_high}) - $signed({4'b0, i_cfg.mode_guard});

        if ({1'b0, i_mode_w} <= low_guard) begin
            fresh_mode = MODE_MANUAL;
        end else if ({1'b0, i_mode_w} < mid_guard) begin
            fresh_mode = MODE_ALTITUDE;
        end else if (i_mode_w <= i_cfg.width_high) begin
            fresh_mode = MODE_NAVIGATE;
        end else begin
            fresh_mode = MODE_ERROR;
        end

        if ({1'b0, i_switch_w} <= low_guard) begin
            fresh_sw = SW_OFF;
        end else if ($signed({2'b0, i_switch_w}) >= high_guard
                     && i_switch_w <= i_cfg.width_high) begin
            fresh_sw = SW_ON;
        end else begin
            fresh_sw = SW_ERROR;
        end

        // Mode debounce
        mode_inc    = r_mode_cnt + 8'd1;
        n_held_mode = r_held_mode;
        n_mode_cnt  = 8'd0;
        if (fresh_mode != r_held_mode) begin
            if (mode_inc > i_cfg.switch_delay) begin
                n_held_mode = fresh_mode;
            end else begin
                n_mode_cnt = mode_inc;
            end
        end

        // Switch debounce
        sw_inc    = r_sw_cnt + 8'd1;
        n_held_sw = r_held_sw;
        n_sw_cnt  = 8'd0;
        if (fresh_sw != r_held_sw) begin
            if (sw_inc > i_cfg.switch_delay) begin
                n_held_sw = fresh_sw;
            end else begin
                n_sw_cnt = sw_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_mode <= MODE_ERROR;
            r_mode_cnt  <= 8'd0;
            r_held_sw   <= SW_ERROR;
            r_sw_cnt    <= 8'd0;
        end else if (i_update) begin
            r_held_mode <= n_held_mode;
            r_mode_cnt  <= n_mode_cnt;
            r_held_sw   <= n_held_sw;
            r_sw_cnt    <= n_sw_cnt;
        end
    end

    // Values after this frame's update, taken by the output register
    assign o_mode   = n_held_mode;
    assign o_switch = n_held_sw;

endmodule

FILE: sv/rc_pulse_input_conditioner.sv
// Sequence: after an input transfer, thrust, the three axes and tune are each
//   prepared, checked and then run through the shared divider; a channel that
//   resolves to zero or full scale skips the divider.
// Frames: a new frame is taken only after the last is emitted; the input is not
//   ready meanwhile, and a result waiting at the output holds the emit step.
// Reset: synchronous active low; registers take their default values, held
//   mode goes to error, held switch to error, mismatch counters clear.
// ----------------------------------------------------------------------------
// rc_pulse_input_conditioner
// Conditions one radio frame of seven pulse widths: clamp, dead band rescale
// of thrust and axes to Q(FRACTION_BITS), tune centering and mode/switch
// classification with debounce. One shared divider serves thrust, axes and tune.
// ----------------------------------------------------------------------------
module rc_pulse_input_conditioner #(
    parameter int WIDTH_BITS    = 18,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rpic_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rpic_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // Input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata, low bit up: thrust_width, roll_width, pitch_width, yaw_width,
    // mode_width, switch_width, tune_width (WIDTH_BITS each), zero pad
    input  logic [((7*WIDTH_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // Output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata, low bit up: thrust_level (F+1), rot_x, rot_y, rot_z (F+2 each),
    // tune_level (F+1), flight_mode (2), switch_state (2), zero pad
    output logic [((5*FRACTION_BITS+19)/8)*8-1:0] m_axis_tdata
);
    import rpic_pkg::*;

    localparam int F      = FRACTION_BITS;
    localparam int OUT_W  = ((5*FRACTION_BITS+19)/8)*8;
    localparam int CW     = (WIDTH_BITS > CNT_W) ? WIDTH_BITS : CNT_W;
    localparam int SW     = CNT_W + 3;   // signed working width

    localparam logic [F:0] ONE_Q  = {1'b1, {F{1'b0}}};
    localparam logic [F:0] HALF_Q = {2'b01, {(F-1){1'b0}}};

    // Channel order through the sequencer
    localparam logic [2:0] CH_THRUST = 3'd0;
    localparam logic [2:0] CH_ROLL   = 3'd1;
    localparam logic [2:0] CH_PITCH  = 3'd2;
    localparam logic [2:0] CH_YAW    = 3'd3;
    localparam logic [2:0] CH_TUNE   = 3'd4;
    localparam logic [2:0] CH_MODE   = 3'd5;
    localparam logic [2:0] CH_SWITCH = 3'd6;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // ------------------------------------------------------------------
    // Configuration registers; writes are always taken
    // ------------------------------------------------------------------
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_low    <= RST_WIDTH_LOW;
            r_cfg.width_high   <= RST_WIDTH_HIGH;
            r_cfg.width_mid    <= RST_WIDTH_MID;
            r_cfg.dead_margin  <= RST_DEAD_MARGIN;
            r_cfg.dead_width   <= RST_DEAD_WIDTH;
            r_cfg.mode_guard   <= RST_MODE_GUARD;
            r_cfg.switch_delay <= RST_SWITCH_DELAY;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH_LOW:    r_cfg.width_low    <= i_cfg_data[17:0];
                CFG_WIDTH_HIGH:   r_cfg.width_high   <= i_cfg_data[17:0];
                CFG_WIDTH_MID:    r_cfg.width_mid    <= i_cfg_data[17:0];
                CFG_DEAD_MARGIN:  r_cfg.dead_margin  <= i_cfg_data[15:0];
                CFG_DEAD_WIDTH:   r_cfg.dead_width   <= i_cfg_data[17:0];
                CFG_MODE_GUARD:   r_cfg.mode_guard   <= i_cfg_data[15:0];
                CFG_SWITCH_DELAY: r_cfg.switch_delay <= i_cfg_data[7:0];
                default: ;        // unused index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and channel registers
    // ------------------------------------------------------------------
    logic [2:0]            r_state;
    logic [2:0]            r_ch;
    logic [WIDTH_BITS-1:0] r_raw [7];
    logic [CNT_W-1:0]      r_mode_w;
    logic [CNT_W-1:0]      r_switch_w;

    logic signed [SW-1:0]  r_num;
    logic signed [SW-1:0]  r_den;
    logic                  r_zero;
    logic                  r_inv;
    logic                  r_half;

    logic [F:0]            r_thrust;
    logic [F+1:0]          r_rot_x;
    logic [F+1:0]          r_rot_y;
    logic [F+1:0]          r_rot_z;
    logic [F:0]            r_tune;

    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;

    logic                  in_xfer;
    logic                  out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Shared clamp on the selected channel
    logic [CW-1:0]    raw_ext;
    logic [CW-1:0]    low_ext;
    logic [CW-1:0]    high_ext;
    logic [CW-1:0]    lift;
    logic [CW-1:0]    clamped;
    logic [CNT_W-1:0] pw;

    always_comb begin
        raw_ext  = CW'(r_raw[r_ch]);
        low_ext  = CW'(r_cfg.width_low);
        high_ext = CW'(r_cfg.width_high);
        lift     = (raw_ext < low_ext) ? low_ext : raw_ext;
        clamped  = (lift > high_ext) ? high_ext : lift;
        pw       = clamped[CNT_W-1:0];   // never above the larger bound
    end

    // Per channel numerator, denominator and dead band decision
    logic signed [SW-1:0] p_s;
    logic signed [SW-1:0] low_s;
    logic signed [SW-1:0] high_s;
    logic signed [SW-1:0] mid_s;
    logic signed [SW-1:0] marg_s;
    logic signed [SW-1:0] lo_edge;
    logic signed [SW-1:0] hi_edge;
    logic                 is_dead;
    logic                 below;
    logic                 above;
    logic signed [SW-1:0] n_num;
    logic signed [SW-1:0] n_den;
    logic                 n_zero;
    logic                 n_inv;
    logic                 n_half;

    always_comb begin
        p_s     = $signed(SW'(pw));
        low_s   = $signed(SW'(r_cfg.width_low));
        high_s  = $signed(SW'(r_cfg.width_high));
        mid_s   = $signed(SW'(r_cfg.width_mid));
        marg_s  = $signed(SW'(r_cfg.dead_margin));
        lo_edge = mid_s - marg_s;
        hi_edge = mid_s + marg_s;
        is_dead = (pw == r_cfg.dead_width);
        below   = p_s < lo_edge;
        above   = p_s > hi_edge;

        if (r_ch == CH_THRUST) begin
            n_num  = p_s - low_s - marg_s;
            n_den  = high_s - low_s - marg_s;
            n_zero = is_dead || !(p_s > low_s + marg_s);
            n_inv  = 1'b0;
            n_half = 1'b0;
        end else if (r_ch == CH_TUNE) begin
            n_num  = p_s - mid_s;
            n_den  = high_s - low_s;
            n_zero = !(n_den > 0);
            n_inv  = 1'b0;
            n_half = 1'b1;
        end else begin
            // Axes: dead band round the centre, output inverted
            n_num  = below ? (p_s - lo_edge) : (p_s - hi_edge);
            n_den  = mid_s - low_s - marg_s;
            n_zero = is_dead || (!below && !above);
            n_inv  = 1'b1;
            n_half = 1'b0;
        end
    end

    // Decide: zero, full scale, or run the divider
    logic [SW-1:0] abs_num;
    logic          den_pos;
    logic          chk_zero;
    logic          chk_full;
    logic [F:0]    lim;
    logic          div_done;
    logic [F-1:0]  div_quo;
    t_div_req      div_req;
    logic [F:0]    res_mag;
    logic          res_we;
    logic [F+1:0]  res_val;

    always_comb begin
        abs_num  = r_num[SW-1] ? SW'(-r_num) : SW'(r_num);
        den_pos  = !r_den[SW-1] && (r_den != '0);
        chk_zero = r_zero || (r_num == '0);
        chk_full = !den_pos || (abs_num >= SW'(r_den));
        lim      = r_half ? HALF_Q : ONE_Q;

        div_req.start = (r_state == S_CHK) && !chk_zero && !chk_full;
        div_req.num   = abs_num[MAG_W-1:0];
        div_req.den   = r_den[MAG_W-1:0];

        res_mag = '0;
        res_we  = 1'b0;
        if (r_state == S_CHK) begin
            if (chk_zero) begin
                res_we = 1'b1;
            end else if (chk_full) begin
                res_mag = lim;
                res_we  = 1'b1;
            end
        end else if (r_state == S_DIV && div_done) begin
            res_mag = {1'b0, div_quo};
            if (r_half && res_mag > HALF_Q) begin
                res_mag = HALF_Q;
            end
            res_we = 1'b1;
        end

        // Truncate toward zero: apply the sign to the magnitude
        res_val = (r_num[SW-1] ^ r_inv) ? (F+2)'(-{1'b0, res_mag})
                                        : {1'b0, res_mag};
    end

    rpic_divider #(
        .FRACTION_BITS (F)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Mode and switch classification with debounce
    logic       emit;
    logic [1:0] flt_mode;
    logic [1:0] flt_switch;

    assign emit = (r_state == S_EMIT) && out_free;

    rpic_mode_filter u_mode_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_mode_w   (r_mode_w),
        .i_switch_w (r_switch_w),
        .i_update   (emit),
        .o_mode     (flt_mode),
        .o_switch   (flt_switch)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= CH_THRUST;
            r_out_valid <= 1'b0;
        end else begin
            // Load a new result, or drop the old one once it is taken
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_ch    <= CH_THRUST;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_ch == CH_SWITCH) begin
                        r_state <= S_EMIT;
                    end else if (r_ch == CH_MODE) begin
                        r_ch <= r_ch + 3'd1;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (res_we) begin
                        r_ch    <= r_ch + 3'd1;
                        r_state <= S_PREP;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (res_we) begin
                        r_ch    <= r_ch + 3'd1;
                        r_state <= S_PREP;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            // Store each width under the channel that reads it; tune runs
            // ahead of mode and switch in the sequence
            for (int k = 0; k < 4; k++) begin
                r_raw[k] <= s_axis_tdata[k*WIDTH_BITS +: WIDTH_BITS];
            end
            r_raw[CH_MODE]   <= s_axis_tdata[4*WIDTH_BITS +: WIDTH_BITS];
            r_raw[CH_SWITCH] <= s_axis_tdata[5*WIDTH_BITS +: WIDTH_BITS];
            r_raw[CH_TUNE]   <= s_axis_tdata[6*WIDTH_BITS +: WIDTH_BITS];
        end
        if (r_state == S_PREP) begin
            r_num  <= n_num;
            r_den  <= n_den;
            r_zero <= n_zero;
            r_inv  <= n_inv;
            r_half <= n_half;
            if (r_ch == CH_MODE) begin
                r_mode_w <= pw;
            end
            if (r_ch == CH_SWITCH) begin
                r_switch_w <= pw;
            end
        end
        if (res_we) begin
            case (r_ch)
                CH_THRUST: r_thrust <= res_mag;
                CH_ROLL:   r_rot_x  <= res_val;
                CH_PITCH:  r_rot_y  <= res_val;
                CH_YAW:    r_rot_z  <= res_val;
                CH_TUNE:   r_tune   <= res_val[F:0];
                default: ;
            endcase
        end
        if (emit) begin
            r_out_data <= OUT_W'({flt_switch, flt_mode, r_tune, r_rot_z, r_rot_y,
                                  r_rot_x, r_thrust});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
